// File: sv/leb_pkg.sv
// Shared types and constants for the line edit buffer.
// No dependencies; imported by every module of the block.
package leb_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int CW               = 7;
  localparam int CHW              = 8;

  localparam logic [CW-1:0]  CAP_RESET = 7'd64;
  localparam logic [CHW-1:0] CHAR_MIN  = 8'h20;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_BACKSPACE = 3'd1,
    ACT_LEFT      = 3'd2,
    ACT_RIGHT     = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_READ      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_CONTROL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHR,
    S_SHL,
    S_READ,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic           valid;
    status_t        status;
    logic [CW-1:0]  cursor;
    logic [CW-1:0]  length;
    logic [CHW-1:0] ch;
    logic           chv;
    logic           last;
  } emit_t;

endpackage

// File: sv/leb_if.sv
// Valid/ready channel interfaces for the line edit buffer.
// Depends on nothing; used by the top level.
interface leb_in_if ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink (input valid, input action, input char_in, output ready);
endinterface

interface leb_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] cursor_pos;
  logic [6:0] line_length;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last;

  modport source (output valid, output status, output cursor_pos, output line_length,
                  output out_char, output char_valid, output last, input ready);
  modport sink (input valid, input status, input cursor_pos, input line_length,
                input out_char, input char_valid, input last, output ready);
endinterface

// File: sv/line_edit_buffer.sv
// Top level of the line edit buffer: capacity register, result register,
// sequencer and line memory. Depends on leb_pkg, leb_if, leb_ctrl, leb_store.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  action[2:0], char_in[7:0]
//   out_ch   out  valid/ready  status, cursor_pos, line_length, out_char,
//                              char_valid, last
//   cfg      in   cfg_we       cfg_wdata[6:0] -> capacity
//
// One word at a time. Left, right, clear, refused inserts and empty reads go from decode to the result.
// Insert and backspace first shift the entries between cursor and end of line, then give the result,
// moving one entry per cycle through the memory read and write ports.
// Read: one character per cycle from the memory read port while the output register is free.
// A stalled result holds in the output register; the sequencer waits on it.
// Reset (synchronous, rst_n low) empties the line and sets capacity to 64.
module line_edit_buffer import leb_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  leb_in_if.sink        in_ch,
  leb_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [CW-1:0]  cap_r;
  logic           out_valid_r, out_valid_nxt;
  emit_t          out_r;
  emit_t          emit;
  logic           out_free;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [CHW-1:0] mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [CHW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_r <= emit;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.cursor_pos  = out_r.cursor;
  assign out_ch.line_length = out_r.length;
  assign out_ch.out_char    = out_r.ch;
  assign out_ch.char_valid  = out_r.chv;
  assign out_ch.last        = out_r.last;

  leb_ctrl #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_action(in_ch.action),
    .in_char  (in_ch.char_in),
    .in_ready (in_ch.ready),
    .cap      (cap_r),
    .out_free (out_free),
    .emit     (emit),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  leb_store #(
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .rdata_r(mem_rdata)
  );

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result produced while output register is occupied");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("word accepted while previous word still in progress");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (emit.cursor <= emit.length) && (emit.length <= CW'(BUFFER_DEPTH)))
    else $error("cursor or length out of range");

  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && !emit.chv) |-> emit.last)
    else $error("non-character result not marked last");

endmodule

// File: sv/leb_store.sv
// Line character memory: one write port, one read port with registered data.
// Depends on leb_pkg.
module leb_store import leb_pkg::*; #(
  parameter int DEPTH = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  logic [CHW-1:0] wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output logic [CHW-1:0] rdata_r
);

  logic [CHW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: sv/leb_ctrl.sv
// Edit sequencer: decodes actions, moves one memory entry per cycle for
// insert and backspace, and streams the line out on read. Depends on leb_pkg.
module leb_ctrl import leb_pkg::*; #(
  parameter int DEPTH = BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_action,
  input  logic [CHW-1:0] in_char,
  output logic           in_ready,
  input  logic [CW-1:0]  cap,
  input  logic           out_free,
  output emit_t          emit,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [CHW-1:0] mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  logic [CHW-1:0] mem_rdata
);

  localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);

  fsm_t           state_r, state_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic [CW-1:0]  length_r, length_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  waddr_r, waddr_nxt;
  logic           pend_r, pend_nxt;
  status_t        status_r, status_nxt;
  logic [CHW-1:0] char_r, char_nxt;
  logic [CW-1:0]  cap_eff;
  logic [CW-1:0]  idx_dec;

  assign cap_eff = (cap > DEPTH_W) ? DEPTH_W : cap;
  assign idx_dec = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      length_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    waddr_r  <= waddr_nxt;
    status_r <= status_nxt;
    char_r   <= char_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    length_nxt  = length_r;
    idx_nxt     = idx_r;
    waddr_nxt   = waddr_r;
    pend_nxt    = pend_r;
    status_nxt  = status_r;
    char_nxt    = char_r;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = waddr_r[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_r[AW-1:0];
    emit        = '0;
    emit.cursor = cursor_r;
    emit.length = length_r;
    emit.status = status_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          char_nxt   = in_char;
          pend_nxt   = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_EMIT;
          unique case (in_action)
            ACT_INSERT: begin
              if (in_char < CHAR_MIN) begin
                status_nxt = ST_CONTROL;
              end else if (length_r >= cap_eff) begin
                status_nxt = ST_NOCHANGE;
              end else begin
                idx_nxt   = length_r;
                state_nxt = S_SHR;
              end
            end
            ACT_BACKSPACE: begin
              if (cursor_r == '0) begin
                status_nxt = ST_NOCHANGE;
              end else begin
                idx_nxt   = cursor_r;
                state_nxt = S_SHL;
              end
            end
            ACT_LEFT: begin
              if (cursor_r == '0) begin
                status_nxt = ST_NOCHANGE;
              end else begin
                cursor_nxt = cursor_r - 1'b1;
              end
            end
            ACT_RIGHT: begin
              if (cursor_r >= length_r) begin
                status_nxt = ST_NOCHANGE;
              end else begin
                cursor_nxt = cursor_r + 1'b1;
              end
            end
            ACT_CLEAR: begin
              cursor_nxt = '0;
              length_nxt = '0;
            end
            ACT_READ: begin
              if (length_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = CW'(1);
                state_nxt = S_READ;
              end
            end
            default: begin
              status_nxt = ST_NOCHANGE;
            end
          endcase
        end
      end

      S_SHR: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (idx_r > cursor_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          waddr_nxt = idx_r;
          pend_nxt  = 1'b1;
          idx_nxt   = idx_dec;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we     = 1'b1;
            mem_waddr  = cursor_r[AW-1:0];
            mem_wdata  = char_r;
            cursor_nxt = cursor_r + 1'b1;
            length_nxt = length_r + 1'b1;
            state_nxt  = S_EMIT;
          end
        end
      end

      S_SHL: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (idx_r < length_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[AW-1:0];
          waddr_nxt = idx_dec;
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cursor_nxt = cursor_r - 1'b1;
            length_nxt = length_r - 1'b1;
            state_nxt  = S_EMIT;
          end
        end
      end

      S_READ: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.status = ST_DONE;
          emit.ch     = mem_rdata;
          emit.chv    = 1'b1;
          emit.last   = (idx_r == length_r);
          if (idx_r == length_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
